// File: rtl/isr_pkg.sv
// ----------------------------------------------------------------------------
// Integer square root package
// Shared constants for the square root cell chain and its output stage.
// ----------------------------------------------------------------------------
package isr_pkg;

    // Width of the radicand when the top level is left at its default.
    localparam int DEFAULT_INPUT_WIDTH = 31;

    // Number of root bits, and so of cells, at the default radicand width.
    localparam int DEFAULT_ROOT_BITS = (DEFAULT_INPUT_WIDTH + 1) / 2;

    // The root field is fixed at 16 bits and saturates above that.
    localparam int ROOT_WIDTH = 16;
    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = '1;

endpackage

// File: rtl/isr_cell.sv
// ----------------------------------------------------------------------------
// Integer square root cell
// One restoring step: brings down two radicand bits, tries the next root bit
// and hands the partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
module isr_cell #(
    parameter int ROOT_BITS = isr_pkg::DEFAULT_ROOT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  logic                   i_valid,
    input  logic [2*ROOT_BITS-1:0] i_rad,
    input  logic [ROOT_BITS:0]     i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    output logic                   o_valid,
    output logic [2*ROOT_BITS-1:0] o_rad,
    output logic [ROOT_BITS:0]     o_rem,
    output logic [ROOT_BITS-1:0]   o_root
);

    localparam int RAD_WIDTH  = 2 * ROOT_BITS;
    localparam int WORK_WIDTH = ROOT_BITS + 3;

    logic                   r_valid;
    logic [RAD_WIDTH-1:0]   r_rad;
    logic [ROOT_BITS:0]     r_rem;
    logic [ROOT_BITS-1:0]   r_root;

    logic [RAD_WIDTH-1:0]   n_rad;
    logic [ROOT_BITS:0]     n_rem;
    logic [ROOT_BITS-1:0]   n_root;

    logic [WORK_WIDTH-1:0]  work;
    logic [WORK_WIDTH-1:0]  trial;
    logic [WORK_WIDTH-1:0]  diff;
    logic [RAD_WIDTH+1:0]   rad_shift;
    logic [ROOT_BITS:0]     root_shift;
    logic                   take;

    always_comb begin
        // Remainder with the next two radicand bits appended, against 4*root+1.
        work       = {i_rem, i_rad[RAD_WIDTH-1 -: 2]};
        trial      = {1'b0, i_root, 2'b01};
        diff       = work - trial;
        take       = (work >= trial);
        rad_shift  = {i_rad, 2'b00};
        root_shift = {i_root, take};
        n_rad      = rad_shift[RAD_WIDTH-1:0];
        n_root     = root_shift[ROOT_BITS-1:0];
        n_rem      = take ? diff[ROOT_BITS:0] : work[ROOT_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

// File: rtl/isr_out.sv
// ----------------------------------------------------------------------------
// Integer square root output stage
// Holds the finished root until the consumer takes it, saturating roots that
// do not fit the 16-bit field.
// ----------------------------------------------------------------------------
module isr_out #(
    parameter int ROOT_BITS = isr_pkg::DEFAULT_ROOT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic                            i_valid,
    input  logic [ROOT_BITS-1:0]            i_root,
    output logic                            o_valid,
    output logic [isr_pkg::ROOT_WIDTH-1:0]  o_root
);

    logic                            r_valid;
    logic [isr_pkg::ROOT_WIDTH-1:0]  r_root;
    logic [isr_pkg::ROOT_WIDTH-1:0]  n_root;

    generate
        if (ROOT_BITS > isr_pkg::ROOT_WIDTH) begin : g_sat
            assign n_root = (|i_root[ROOT_BITS-1:isr_pkg::ROOT_WIDTH]) ?
                            isr_pkg::ROOT_MAX : i_root[isr_pkg::ROOT_WIDTH-1:0];
        end else begin : g_ext
            always_comb begin
                n_root                = '0;
                n_root[ROOT_BITS-1:0] = i_root;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule

// File: rtl/integer_square_root_unit.sv
// Path: an accepted request passes through the ROOT_BITS cell registers and then the
// output register to o_valid, where ROOT_BITS = (INPUT_WIDTH + 1) / 2 and INPUT_WIDTH defaults to 31.
// Throughput: one request per cycle; the chain of ROOT_BITS cells, one per
// root bit, moves as a whole and halts only while a finished root is stalled.
// Reset (i_rst_n low, synchronous) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// Integer square root unit
// Floor of the square root of an unsigned radicand, one root bit per cell.
// ----------------------------------------------------------------------------
module integer_square_root_unit #(
    parameter int INPUT_WIDTH = isr_pkg::DEFAULT_INPUT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [INPUT_WIDTH-1:0]          i_radicand,
    output logic                            o_stall,
    output logic                            o_valid,
    output logic [isr_pkg::ROOT_WIDTH-1:0]  o_root,
    input  logic                            i_stall
);

    localparam int ROOT_BITS = (INPUT_WIDTH + 1) / 2;
    localparam int RAD_WIDTH = 2 * ROOT_BITS;

    logic                  advance;
    logic [RAD_WIDTH-1:0]  rad_pad;

    // Index k holds what enters cell k; the last cell's root and valid land
    // at index ROOT_BITS.
    logic                  w_valid [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]  w_root  [0:ROOT_BITS];
    logic [RAD_WIDTH-1:0]  w_rad   [0:ROOT_BITS-1];
    logic [ROOT_BITS:0]    w_rem   [0:ROOT_BITS-1];

    // The whole chain moves unless a finished root is waiting and stalled.
    assign advance = !(o_valid && i_stall);
    assign o_stall = !advance;

    always_comb begin
        rad_pad                  = '0;
        rad_pad[INPUT_WIDTH-1:0] = i_radicand;
    end

    assign w_valid[0] = i_valid;
    assign w_rad[0]   = rad_pad;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;

    generate
        for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
            if (k < ROOT_BITS - 1) begin : g_mid
                isr_cell #(
                    .ROOT_BITS (ROOT_BITS)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_advance (advance),
                    .i_valid   (w_valid[k]),
                    .i_rad     (w_rad[k]),
                    .i_rem     (w_rem[k]),
                    .i_root    (w_root[k]),
                    .o_valid   (w_valid[k+1]),
                    .o_rad     (w_rad[k+1]),
                    .o_rem     (w_rem[k+1]),
                    .o_root    (w_root[k+1])
                );
            end else begin : g_last
                isr_cell #(
                    .ROOT_BITS (ROOT_BITS)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_advance (advance),
                    .i_valid   (w_valid[k]),
                    .i_rad     (w_rad[k]),
                    .i_rem     (w_rem[k]),
                    .i_root    (w_root[k]),
                    .o_valid   (w_valid[k+1]),
                    .o_rad     (),
                    .o_rem     (),
                    .o_root    (w_root[k+1])
                );
            end
        end
    endgenerate

    isr_out #(
        .ROOT_BITS (ROOT_BITS)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (w_valid[ROOT_BITS]),
        .i_root    (w_root[ROOT_BITS]),
        .o_valid   (o_valid),
        .o_root    (o_root)
    );

    // A reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending right after reset");

    // An accepted request always enters the first cell.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[1])
        else $error("accepted request did not enter the chain");

    // A root leaving the last cell while the chain moves becomes a result.
    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[ROOT_BITS] && advance) |=> o_valid)
        else $error("root from the last cell was lost");

    // While the chain is held, the first cell keeps its occupancy.
    a_hold_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(w_valid[1]))
        else $error("chain moved while held");

endmodule

// File: dv/isr_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root result checker
// Watches the request and result channels of the square root unit, predicts
// the floor root of every accepted radicand, and compares results in order.
// ----------------------------------------------------------------------------
module isr_result_checker #(
    parameter int INPUT_WIDTH = isr_pkg::DEFAULT_INPUT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [INPUT_WIDTH-1:0]          i_req_radicand,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [isr_pkg::ROOT_WIDTH-1:0]  i_res_root,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_checked
);

    typedef struct {
        logic [INPUT_WIDTH-1:0]          radicand;
        logic [isr_pkg::ROOT_WIDTH-1:0]  root;
    } t_root_entry;

    t_root_entry pending_roots[$];
    t_root_entry oldest;
    t_root_entry fresh;
    int          mismatch_total = 0;
    int          checked_total = 0;

    // Builds the root one bit at a time from the top, keeping a bit whenever
    // the square of the trial root still fits under the radicand.
    function automatic logic [isr_pkg::ROOT_WIDTH-1:0] floor_root(
        input logic [INPUT_WIDTH-1:0] radicand
    );
        logic [127:0] target;
        logic [63:0]  guess;
        logic [63:0]  trial;
        target = 128'(radicand);
        guess = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = guess | (64'd1 << b);
            if (128'(trial) * 128'(trial) <= target) begin
                guess = trial;
            end
        end
        if (guess > 64'(isr_pkg::ROOT_MAX)) begin
            return isr_pkg::ROOT_MAX;
        end
        return guess[isr_pkg::ROOT_WIDTH-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Results are taken before requests so that a result can never be
            // matched against a request accepted at the same edge.
            if (i_res_valid && !i_res_stall) begin
                if (pending_roots.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("[%0t] unexpected result: root %0d with no request waiting",
                                 $realtime, i_res_root);
                    end
                end else begin
                    oldest = pending_roots.pop_front();
                    checked_total++;
                    if (i_res_root !== oldest.root) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("[%0t] root mismatch: radicand %0d expected %0d got %0d",
                                     $realtime, oldest.radicand, oldest.root, i_res_root);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                fresh.radicand = i_req_radicand;
                fresh.root = floor_root(i_req_radicand);
                pending_roots.push_back(fresh);
            end
        end
        o_mismatches <= mismatch_total;
        o_outstanding <= pending_roots.size();
        o_checked <= checked_total;
    end

endmodule

// File: dv/tb_integer_square_root_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root unit testbench
// Sends directed and random radicands through the unit under several mixes
// of request gaps and result back-pressure; the checker judges every root.
// ----------------------------------------------------------------------------
module tb_integer_square_root_unit;

    localparam int W = isr_pkg::DEFAULT_INPUT_WIDTH;
    // Largest root a 31-bit radicand can have.
    localparam int unsigned TOP_ROOT = 46340;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_BIT_LENGTH,
        SHAPE_SQUARE_EDGE,
        SHAPE_SMALL,
        SHAPE_NEAR_TOP
    } t_radicand_shape;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic [W-1:0]                    i_radicand;
    logic                            o_stall;
    logic                            o_valid;
    logic [isr_pkg::ROOT_WIDTH-1:0]  o_root;
    logic                            i_stall;

    int mismatches;
    int outstanding;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent_count = 0;
    int cycle_count = 0;

    integer_square_root_unit #(
        .INPUT_WIDTH (W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_radicand (i_radicand),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_root     (o_root),
        .i_stall    (i_stall)
    );

    isr_result_checker #(
        .INPUT_WIDTH (W)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_radicand (i_radicand),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_res_root     (o_root),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [W-1:0] random_radicand();
        logic [63:0]  full_mask;
        logic [63:0]  pick;
        logic [63:0]  square;
        int unsigned  root;
        int unsigned  bits;
        full_mask = (64'd1 << W) - 1;
        case (t_radicand_shape'($urandom_range(SHAPE_NEAR_TOP)))
            SHAPE_UNIFORM: begin
                pick = {$urandom(), $urandom()};
            end
            SHAPE_BIT_LENGTH: begin
                bits = $urandom_range(W, 1);
                pick = {$urandom(), $urandom()} & ((64'd1 << bits) - 1);
            end
            SHAPE_SQUARE_EDGE: begin
                // Perfect squares and their neighbors are where a root bit
                // decision flips.
                root = $urandom_range(TOP_ROOT);
                square = 64'(root) * 64'(root);
                case ($urandom_range(2))
                    0: pick = (square == 0) ? square : square - 1;
                    1: pick = square;
                    default: pick = square + 1;
                endcase
            end
            SHAPE_SMALL: begin
                pick = 64'($urandom_range(300));
            end
            default: begin
                pick = full_mask - 64'($urandom_range(100000));
            end
        endcase
        return W'(pick & full_mask);
    endfunction

    task automatic send_request(input logic [W-1:0] value);
        while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_radicand <= value;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Holds off new requests until every outstanding root has been returned.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int sender_idle, input int receiver_stall);
        idle_pct = sender_idle;
        stall_pct <= receiver_stall;
        repeat (RANDOM_PER_PHASE) begin
            send_request(random_radicand());
        end
        wait_for_drain();
    endtask

    logic [W-1:0] directed_values[] = '{
        W'(0), W'(1), W'(2), W'(3), W'(4), W'(8), W'(9), W'(15), W'(16),
        W'(24), W'(25), W'(255), W'(256), W'(65535), W'(65536),
        W'(32'h3FFF_FFFF), W'(32'h4000_0000),
        W'(64'(TOP_ROOT) * 64'(TOP_ROOT) - 1), W'(64'(TOP_ROOT) * 64'(TOP_ROOT)),
        W'(32'h5555_5555), W'(32'h2AAA_AAAA), W'(32'h7FFF_FFFF)
    };

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_radicand <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_values[k]) begin
            send_request(directed_values[k]);
        end
        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(10, 10);

        stall_pct <= 0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d checked roots: edge radicands, perfect-square",
                 sent_count, checked);
        $display("boundaries and random widths, under four gap and back-pressure mixes.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
